/* rtl/hplv_pkg.sv */
// Package for the header parameter list validator: constants, codes and beat types.
package hplv_pkg;

    localparam int unsigned MAX_ID_DIGITS_DEF = 6;
    localparam int unsigned ID_W              = 20;
    localparam logic [ID_W-1:0] ID_LIMIT      = 20'd999999;
    localparam int unsigned ACC_W             = ID_W + 4;

    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_IDENT = 2'd1,
        MODE_KEY   = 2'd2,
        MODE_VALUE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ROLE_DIGIT  = 3'd0,
        ROLE_KEY    = 3'd1,
        ROLE_EQUALS = 3'd2,
        ROLE_VALUE  = 3'd3,
        ROLE_COMMA  = 3'd4,
        ROLE_REJECT = 3'd5,
        ROLE_END    = 3'd6
    } role_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]      byte_role;
        logic            done_res;
        logic            list_valid;
        logic            has_ident;
        logic [ID_W-1:0] ident_value;
    } out_item_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_bad_value(input logic [7:0] c);
        return (c == CH_EQUALS) || (c == CH_SPACE) || (c == CH_COMMA) ||
               (c == CH_COLON) || (c == CH_LT) || (c == CH_NUL);
    endfunction

endpackage

/* rtl/hplv_stream_if.sv */
// Valid/ready stream interface carrying one payload per beat.
interface hplv_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/header_param_list_validator_top.sv */
// Header parameter list validator: top level with input register, parser and result register.
//
// Takes one list byte (or an end marker) per beat and returns one classification
// beat for each, a byte role for list bytes and validity plus the last numeric
// identifier for the end marker. Each input beat passes the input register, the
// parser update and the result register in turn; one beat per cycle is sustained
// while the result side is ready. Backpressure on the result side stalls both
// stages together. After an end marker the parser is back in its reset state,
// ready for the next list.
module header_param_list_validator_top #(
    parameter int unsigned MAX_ID_DIGITS = hplv_pkg::MAX_ID_DIGITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    hplv_stream_if.sink   item,
    hplv_stream_if.source result
);

    localparam int unsigned DCW = $clog2(MAX_ID_DIGITS + 1);
    localparam logic [DCW:0] MAX_DIG = (DCW + 1)'(MAX_ID_DIGITS);

    // input stage
    logic                 s1_valid_reg;
    hplv_pkg::in_item_t   s1_item_reg;

    // parser state
    hplv_pkg::mode_t               mode_reg, mode_next;
    logic [DCW-1:0]                count_reg, count_next;
    logic [hplv_pkg::ID_W-1:0]     accum_reg, accum_next;
    logic [hplv_pkg::ID_W-1:0]     saved_reg, saved_next;
    logic                          err_reg, err_next;

    // result stage
    logic                 out_valid_reg;
    hplv_pkg::out_item_t  out_item_reg, out_item_next;

    logic advance;
    logic fire;

    logic [hplv_pkg::ACC_W-1:0] acc_wide;
    logic [hplv_pkg::ACC_W-1:0] acc_try;
    logic [DCW:0]               count_inc;
    logic                       dig_ok;
    logic [7:0]                 c;
    hplv_pkg::role_t            role;
    logic                       end_valid;
    logic [hplv_pkg::ID_W-1:0]  end_id;

    assign advance      = !out_valid_reg || result.ready;
    assign item.ready   = !s1_valid_reg || advance;
    assign fire         = s1_valid_reg && advance;
    assign result.valid = out_valid_reg;
    assign result.payload = out_item_reg;

    assign c         = s1_item_reg.byte_value;
    assign acc_wide  = hplv_pkg::ACC_W'(accum_reg);
    assign acc_try   = (acc_wide << 3) + (acc_wide << 1) + hplv_pkg::ACC_W'(c[3:0]);
    assign count_inc = {1'b0, count_reg} + (DCW + 1)'(1);
    assign dig_ok    = (count_inc <= MAX_DIG) &&
                       (acc_try <= hplv_pkg::ACC_W'(hplv_pkg::ID_LIMIT));

    always_comb
    begin
        mode_next     = mode_reg;
        count_next    = count_reg;
        accum_next    = accum_reg;
        saved_next    = saved_reg;
        err_next      = err_reg;
        out_item_next = out_item_reg;
        role          = hplv_pkg::ROLE_REJECT;
        end_valid     = !err_reg;
        end_id        = (!err_reg && mode_reg == hplv_pkg::MODE_IDENT) ? accum_reg : saved_reg;

        if (fire)
        begin
            if (s1_item_reg.kind == hplv_pkg::KIND_BYTE)
            begin
                if (!err_reg)
                begin
                    unique case (mode_reg)
                        hplv_pkg::MODE_START:
                        begin
                            if (hplv_pkg::is_digit(c) && c != 8'h30)
                            begin
                                accum_next = hplv_pkg::ID_W'(c[3:0]);
                                count_next = DCW'(1);
                                mode_next  = hplv_pkg::MODE_IDENT;
                                role       = hplv_pkg::ROLE_DIGIT;
                            end
                            else if (hplv_pkg::is_letter(c))
                            begin
                                mode_next = hplv_pkg::MODE_KEY;
                                role      = hplv_pkg::ROLE_KEY;
                            end
                        end
                        hplv_pkg::MODE_IDENT:
                        begin
                            if (hplv_pkg::is_digit(c))
                            begin
                                if (dig_ok)
                                begin
                                    accum_next = acc_try[hplv_pkg::ID_W-1:0];
                                    count_next = count_inc[DCW-1:0];
                                    role       = hplv_pkg::ROLE_DIGIT;
                                end
                            end
                            else if (c == hplv_pkg::CH_COMMA)
                            begin
                                saved_next = accum_reg;
                                mode_next  = hplv_pkg::MODE_START;
                                role       = hplv_pkg::ROLE_COMMA;
                            end
                        end
                        hplv_pkg::MODE_KEY:
                        begin
                            if (hplv_pkg::is_letter(c) || hplv_pkg::is_digit(c))
                                role = hplv_pkg::ROLE_KEY;
                            else if (c == hplv_pkg::CH_EQUALS)
                            begin
                                mode_next = hplv_pkg::MODE_VALUE;
                                role      = hplv_pkg::ROLE_EQUALS;
                            end
                            else if (c == hplv_pkg::CH_COMMA)
                            begin
                                mode_next = hplv_pkg::MODE_START;
                                role      = hplv_pkg::ROLE_COMMA;
                            end
                        end
                        hplv_pkg::MODE_VALUE:
                        begin
                            if (c == hplv_pkg::CH_COMMA)
                            begin
                                mode_next = hplv_pkg::MODE_START;
                                role      = hplv_pkg::ROLE_COMMA;
                            end
                            else if (!hplv_pkg::is_bad_value(c))
                                role = hplv_pkg::ROLE_VALUE;
                        end
                        default: ;
                    endcase
                    if (role == hplv_pkg::ROLE_REJECT)
                        err_next = 1'b1;
                end
                out_item_next.byte_role   = role;
                out_item_next.done_res    = 1'b0;
                out_item_next.list_valid  = !err_next;
                out_item_next.has_ident   = 1'b0;
                out_item_next.ident_value = '0;
            end
            else
            begin
                out_item_next.byte_role   = hplv_pkg::ROLE_END;
                out_item_next.done_res    = 1'b1;
                out_item_next.list_valid  = end_valid;
                out_item_next.has_ident   = end_valid && (end_id != '0);
                out_item_next.ident_value = end_valid ? end_id : '0;
                // back to reset for the next list
                mode_next  = hplv_pkg::MODE_START;
                count_next = '0;
                accum_next = '0;
                saved_next = '0;
                err_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= hplv_pkg::MODE_START;
            count_reg     <= '0;
            accum_reg     <= '0;
            saved_reg     <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            if (item.ready)
                s1_valid_reg <= item.valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
            mode_reg  <= mode_next;
            count_reg <= count_next;
            accum_reg <= accum_next;
            saved_reg <= saved_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            s1_item_reg <= item.payload;
        if (fire)
            out_item_reg <= out_item_next;
    end

endmodule
